FILE: sv/bba_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Shared widths, map and status codes, controller states and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

  localparam int unsigned CNT_W  = 9;
  localparam int unsigned LEN_W  = 9;
  localparam int unsigned HINT_W = 8;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned IDX_W  = 8;
  localparam int unsigned MAP_W  = 2;

  localparam logic [CNT_W-1:0] COUNT_RESET = 9'd256;

  localparam logic [MAP_W-1:0] BLK_FREE  = 2'd0;
  localparam logic [MAP_W-1:0] BLK_START = 2'd1;
  localparam logic [MAP_W-1:0] BLK_USED  = 2'd2;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_DEALLOC = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_NOSPACE  = 3'd1,
    ST_ZEROLEN  = 3'd2,
    ST_NOTSTART = 3'd3,
    ST_RANGE    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SCAN1,
    S_SCAN2,
    S_WALK,
    S_FILL,
    S_RESP
  } state_e;

  typedef struct packed {
    logic    clr_init;
    logic    clr_step;
    logic    accept;
    logic    pass1;
    logic    pass2;
    logic    walk_init;
    logic    step;
    logic    fill_init;
    logic    fill_step;
    logic    set_res;
    status_e res_status;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic range_err;
    logic zero_len;
    logic too_long;
    logic is_dealloc;
    logic is_start;
    logic hit;
    logic scan_end;
    logic fill_last;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

FILE: sv/bba_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 256
) (
  input  wire                             clk_i,
  input  wire                             we_i,
  input  wire  [$clog2(DEPTH)-1:0]        waddr_i,
  input  wire  [WIDTH-1:0]                wdata_i,
  input  wire  [$clog2(DEPTH)-1:0]        raddr_i,
  output logic [WIDTH-1:0]                rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: sv/bba_ctrl.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator controller
// Sequences the clearing pass, request checks, the two scan passes, the run
// fill, the release walk and the hand-off of each result.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  bba_pkg::stat_t       stat_i,
  output bba_pkg::cmd_t        cmd_o
);

  bba_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bba_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == bba_pkg::S_IDLE) && !cfg_we_i;

  always_comb begin
    state_d = state_q;
    if (cfg_we_i) begin
      state_d = bba_pkg::S_CLEAR;
    end else begin
      unique case (state_q)
        bba_pkg::S_CLEAR: begin
          if (stat_i.clr_last) state_d = bba_pkg::S_IDLE;
        end
        bba_pkg::S_IDLE: begin
          if (in_valid_i) state_d = bba_pkg::S_CHECK;
        end
        bba_pkg::S_CHECK: begin
          priority if (stat_i.range_err) begin
            state_d = bba_pkg::S_RESP;
          end else if (stat_i.is_dealloc) begin
            state_d = stat_i.is_start ? bba_pkg::S_WALK : bba_pkg::S_RESP;
          end else if (stat_i.zero_len || stat_i.too_long) begin
            state_d = bba_pkg::S_RESP;
          end else begin
            state_d = bba_pkg::S_SCAN1;
          end
        end
        bba_pkg::S_SCAN1: begin
          priority if (stat_i.hit) state_d = bba_pkg::S_FILL;
          else if (stat_i.scan_end) state_d = bba_pkg::S_SCAN2;
        end
        bba_pkg::S_SCAN2: begin
          priority if (stat_i.hit) state_d = bba_pkg::S_FILL;
          else if (stat_i.scan_end) state_d = bba_pkg::S_RESP;
        end
        bba_pkg::S_WALK: begin
          if (stat_i.scan_end) state_d = bba_pkg::S_RESP;
        end
        bba_pkg::S_FILL: begin
          if (stat_i.fill_last) state_d = bba_pkg::S_RESP;
        end
        bba_pkg::S_RESP: begin
          if (stat_i.out_free) state_d = bba_pkg::S_IDLE;
        end
        default: state_d = bba_pkg::S_CLEAR;
      endcase
    end
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.res_status = bba_pkg::ST_OK;
    cmd_o.clr_init   = cfg_we_i;
    unique case (state_q)
      bba_pkg::S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
      end
      bba_pkg::S_IDLE: begin
        cmd_o.accept = in_valid_i && !cfg_we_i;
      end
      bba_pkg::S_CHECK: begin
        priority if (stat_i.range_err) begin
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = bba_pkg::ST_RANGE;
        end else if (stat_i.is_dealloc) begin
          if (stat_i.is_start) begin
            cmd_o.walk_init = 1'b1;
          end else begin
            cmd_o.set_res    = 1'b1;
            cmd_o.res_status = bba_pkg::ST_NOTSTART;
          end
        end else if (stat_i.zero_len) begin
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = bba_pkg::ST_ZEROLEN;
        end else if (stat_i.too_long) begin
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = bba_pkg::ST_NOSPACE;
        end else begin
          cmd_o.pass1 = 1'b1;
        end
      end
      bba_pkg::S_SCAN1: begin
        cmd_o.step = 1'b1;
        priority if (stat_i.hit) cmd_o.fill_init = 1'b1;
        else if (stat_i.scan_end) cmd_o.pass2 = 1'b1;
      end
      bba_pkg::S_SCAN2: begin
        cmd_o.step = 1'b1;
        priority if (stat_i.hit) begin
          cmd_o.fill_init = 1'b1;
        end else if (stat_i.scan_end) begin
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = bba_pkg::ST_NOSPACE;
        end
      end
      bba_pkg::S_WALK: begin
        cmd_o.step = 1'b1;
        if (stat_i.scan_end) begin
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = bba_pkg::ST_OK;
        end
      end
      bba_pkg::S_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (stat_i.fill_last) begin
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = bba_pkg::ST_OK;
        end
      end
      bba_pkg::S_RESP: begin
        cmd_o.out_load = stat_i.out_free;
      end
      default: cmd_o.clr_init = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/bba_dp.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator datapath
// Holds the block count, the request, the scan pointers and the result
// register, and drives the block map RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_dp #(
  parameter int unsigned NUM_BLOCKS = 256
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [bba_pkg::CNT_W-1:0]        cfg_count_i,
  input  wire                              op_i,
  input  wire  [bba_pkg::LEN_W-1:0]        length_i,
  input  wire  [bba_pkg::HINT_W-1:0]       start_block_i,
  input  bba_pkg::cmd_t                    cmd_i,
  output bba_pkg::stat_t                   stat_o,
  input  wire                              out_ready_i,
  output logic                             out_valid_o,
  output logic [bba_pkg::STAT_W-1:0]       status_o,
  output logic [bba_pkg::IDX_W-1:0]        block_index_o
);

  localparam int unsigned AW = $clog2(NUM_BLOCKS);
  localparam int unsigned CW = bba_pkg::CNT_W;

  logic [AW-1:0]                  clr_addr_q, clr_addr_d;
  logic [CW-1:0]                  count_q, count_d;
  logic                           pend_q, pend_d;
  logic                           out_valid_q, out_valid_d;

  logic                           op_q, op_d;
  logic [bba_pkg::LEN_W-1:0]      len_q, len_d;
  logic [bba_pkg::HINT_W-1:0]     hint_q, hint_d;
  logic [CW-1:0]                  begin_q, begin_d;
  logic [CW-1:0]                  pos_q, pos_d;
  logic [CW-1:0]                  ev_q, ev_d;
  logic [CW-1:0]                  hi_q, hi_d;
  logic [CW-1:0]                  run_q, run_d;
  logic [CW-1:0]                  base_q, base_d;
  logic [CW-1:0]                  end_q, end_d;
  logic [CW-1:0]                  fp_q, fp_d;
  bba_pkg::status_e               res_status_q, res_status_d;
  logic [bba_pkg::IDX_W-1:0]      res_index_q, res_index_d;
  bba_pkg::status_e               out_status_q, out_status_d;
  logic [bba_pkg::IDX_W-1:0]      out_index_q, out_index_d;

  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [bba_pkg::MAP_W-1:0]      ram_wdata;
  logic [AW-1:0]                  ram_raddr;
  logic [bba_pkg::MAP_W-1:0]      ram_rdata;

  logic [CW-1:0]                  cnt_eff;
  logic [CW-1:0]                  hint_ext;
  logic [CW-1:0]                  run_inc;
  logic [CW-1:0]                  begin_new;
  logic [CW-1:0]                  base_new;
  logic                           issue;
  logic                           rd_free;
  logic                           rd_used;

  bba_ram #(
    .WIDTH (bba_pkg::MAP_W),
    .DEPTH (NUM_BLOCKS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign cnt_eff   = (32'(count_q) > NUM_BLOCKS) ? CW'(NUM_BLOCKS) : count_q;
  assign hint_ext  = CW'(hint_q);
  assign run_inc   = run_q + CW'(1);
  assign issue     = pos_q < hi_q;
  assign rd_free   = pend_q && (ram_rdata == bba_pkg::BLK_FREE);
  assign rd_used   = pend_q && (ram_rdata == bba_pkg::BLK_USED);
  assign begin_new = ((hint_q != '0) && (ram_rdata == bba_pkg::BLK_FREE)) ? '0 : hint_ext;
  assign base_new  = ev_q + CW'(1) - len_q;

  always_comb begin
    stat_o.clr_last   = clr_addr_q == AW'(NUM_BLOCKS - 1);
    stat_o.range_err  = hint_ext >= cnt_eff;
    stat_o.zero_len   = len_q == '0;
    stat_o.too_long   = len_q > cnt_eff;
    stat_o.is_dealloc = op_q == bba_pkg::OP_DEALLOC;
    stat_o.is_start   = ram_rdata == bba_pkg::BLK_START;
    stat_o.hit        = (op_q == bba_pkg::OP_ALLOC) && rd_free && (run_inc == len_q);
    stat_o.scan_end   = (ev_q >= hi_q) ||
                        ((op_q == bba_pkg::OP_DEALLOC) && pend_q &&
                         (ram_rdata != bba_pkg::BLK_USED));
    stat_o.fill_last  = fp_q == end_q;
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr_q;
    ram_wdata = bba_pkg::BLK_FREE;
    priority if (cmd_i.clr_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
    end else if (cmd_i.walk_init) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(hint_q);
    end else if (cmd_i.step && (op_q == bba_pkg::OP_DEALLOC) && rd_used) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(ev_q);
    end else if (cmd_i.fill_step) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(fp_q);
      ram_wdata = (fp_q == base_q) ? bba_pkg::BLK_START : bba_pkg::BLK_USED;
    end
  end

  always_comb begin
    if (cmd_i.accept) begin
      ram_raddr = (op_i == bba_pkg::OP_DEALLOC) ? AW'(start_block_i)
                                                 : AW'(start_block_i - bba_pkg::HINT_W'(1));
    end else begin
      ram_raddr = AW'(pos_q);
    end
  end

  always_comb begin
    clr_addr_d   = clr_addr_q;
    count_d      = count_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q;
    op_d         = op_q;
    len_d        = len_q;
    hint_d       = hint_q;
    begin_d      = begin_q;
    pos_d        = pos_q;
    ev_d         = ev_q;
    hi_d         = hi_q;
    run_d        = run_q;
    base_d       = base_q;
    end_d        = end_q;
    fp_d         = fp_q;
    res_status_d = res_status_q;
    res_index_d  = res_index_q;
    out_status_d = out_status_q;
    out_index_d  = out_index_q;

    if (cfg_we_i) begin
      count_d = cfg_count_i;
    end
    if (cmd_i.clr_init) begin
      clr_addr_d = '0;
    end else if (cmd_i.clr_step) begin
      clr_addr_d = clr_addr_q + AW'(1);
    end

    if (cmd_i.accept) begin
      op_d   = op_i;
      len_d  = length_i;
      hint_d = start_block_i;
    end

    if (cmd_i.pass1) begin
      begin_d = begin_new;
      pos_d   = begin_new;
      ev_d    = begin_new;
      hi_d    = cnt_eff;
      run_d   = '0;
      pend_d  = 1'b0;
    end else if (cmd_i.pass2) begin
      pos_d  = '0;
      ev_d   = '0;
      hi_d   = begin_q;
      run_d  = '0;
      pend_d = 1'b0;
    end else if (cmd_i.walk_init) begin
      pos_d  = hint_ext + CW'(1);
      ev_d   = hint_ext + CW'(1);
      hi_d   = cnt_eff;
      pend_d = 1'b0;
    end else if (cmd_i.step) begin
      pend_d = issue;
      if (issue) begin
        pos_d = pos_q + CW'(1);
      end
      if (op_q == bba_pkg::OP_ALLOC) begin
        if (pend_q) begin
          ev_d  = ev_q + CW'(1);
          run_d = rd_free ? run_inc : '0;
        end
      end else if (rd_used) begin
        ev_d = ev_q + CW'(1);
      end
    end

    if (cmd_i.fill_init) begin
      base_d = base_new;
      fp_d   = base_new;
      end_d  = ev_q;
    end else if (cmd_i.fill_step) begin
      fp_d = fp_q + CW'(1);
    end

    if (cmd_i.set_res) begin
      res_status_d = cmd_i.res_status;
      res_index_d  = ((cmd_i.res_status == bba_pkg::ST_OK) && (op_q == bba_pkg::OP_ALLOC))
                     ? base_q[bba_pkg::IDX_W-1:0] : '0;
    end

    if (cmd_i.out_load) begin
      out_valid_d  = 1'b1;
      out_status_d = res_status_q;
      out_index_d  = res_index_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q  <= '0;
      count_q     <= bba_pkg::COUNT_RESET;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      clr_addr_q  <= clr_addr_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    len_q        <= len_d;
    hint_q       <= hint_d;
    begin_q      <= begin_d;
    pos_q        <= pos_d;
    ev_q         <= ev_d;
    hi_q         <= hi_d;
    run_q        <= run_d;
    base_q       <= base_d;
    end_q        <= end_d;
    fp_q         <= fp_d;
    res_status_q <= res_status_d;
    res_index_q  <= res_index_d;
    out_status_q <= out_status_d;
    out_index_q  <= out_index_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign block_index_o = out_index_q;

endmodule

`default_nettype wire

FILE: sv/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator
// Next-fit allocator over a map of blocks kept in a single-port-read RAM.
// ----------------------------------------------------------------------------
// The block takes one request at a time. The map RAM is read one entry per
// cycle. An allocate checks the request, scans the map in up to two passes
// over the block count and then fills the run, writing one map entry per
// allocated block. A deallocate checks the start entry and walks the run,
// freeing each block. After reset and after every block_count write the map
// is cleared in a pass over all NUM_BLOCKS entries, during which no item is
// accepted. A finished result waits in an output register while the next
// item is taken.
`default_nettype none

module bitmap_block_allocator #(
  parameter int unsigned NUM_BLOCKS = 256
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              block_count_we_i,
  input  wire  [bba_pkg::CNT_W-1:0]        block_count_i,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire                              op_i,
  input  wire  [bba_pkg::LEN_W-1:0]        length_i,
  input  wire  [bba_pkg::HINT_W-1:0]       start_block_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic [bba_pkg::STAT_W-1:0]       status_o,
  output logic [bba_pkg::IDX_W-1:0]        block_index_o
);

  bba_pkg::cmd_t  cmd;
  bba_pkg::stat_t stat;

  bba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (block_count_we_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bba_dp #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (block_count_we_i),
    .cfg_count_i   (block_count_i),
    .op_i          (op_i),
    .length_i      (length_i),
    .start_block_i (start_block_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .status_o      (status_o),
    .block_index_o (block_index_o)
  );

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("A new item was offered ready right after an accepted item.");

  a_clear_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    block_count_we_i |=> !in_ready_o)
    else $error("Items were accepted while the map clear was pending.");

  a_index_zero_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != bba_pkg::ST_OK)) |-> (block_index_o == '0))
    else $error("An error result carried a nonzero block index.");
`endif

endmodule

`default_nettype wire
